// ===== design/yuyv2rgb_pkg.sv =====
package yuyv2rgb_pkg;

    localparam int COEF_W  = 12;
    localparam int BYTE_W  = 8;
    localparam int DIFF_W  = 9;
    localparam int PROD_W  = 22;
    localparam int GSUM_W  = 23;
    localparam int SUM_W   = 24;
    localparam int FRAC_W  = 18;
    localparam int RECIP_W = 19;
    localparam int QPROD_W = FRAC_W + RECIP_W;
    localparam int SHIFT   = 28;

    localparam logic signed [DIFF_W-1:0] LUMA_OFFSET   = 9'sd16;
    localparam logic signed [DIFF_W-1:0] CHROMA_OFFSET = 9'sd128;

    // floor(x / 1000) == (x * RECIP) >> SHIFT for 0 <= x < 256000
    localparam logic [RECIP_W-1:0] RECIP     = 19'd268436;
    localparam logic [SUM_W-1:0]   SAT_LIMIT = 24'd256000;
    localparam logic [BYTE_W-1:0]  CHAN_MAX  = 8'd255;

    localparam logic [COEF_W-1:0] LUMA_GAIN_RST     = 12'd1164;
    localparam logic [COEF_W-1:0] RED_FROM_CR_RST   = 12'd1159;
    localparam logic [COEF_W-1:0] GREEN_FROM_CB_RST = 12'd380;
    localparam logic [COEF_W-1:0] GREEN_FROM_CR_RST = 12'd813;
    localparam logic [COEF_W-1:0] BLUE_FROM_CB_RST  = 12'd2018;

    typedef enum logic [2:0] {
        REG_LUMA_GAIN     = 3'd0,
        REG_RED_FROM_CR   = 3'd1,
        REG_GREEN_FROM_CB = 3'd2,
        REG_GREEN_FROM_CR = 3'd3,
        REG_BLUE_FROM_CB  = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [COEF_W-1:0] luma_gain;
        logic [COEF_W-1:0] red_from_cr;
        logic [COEF_W-1:0] green_from_cb;
        logic [COEF_W-1:0] green_from_cr;
        logic [COEF_W-1:0] blue_from_cb;
    } coef_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] red_first;
        logic signed [SUM_W-1:0] green_first;
        logic signed [SUM_W-1:0] blue_first;
        logic signed [SUM_W-1:0] red_second;
        logic signed [SUM_W-1:0] green_second;
        logic signed [SUM_W-1:0] blue_second;
    } chan_sums_t;

endpackage

// ===== design/yuyv2rgb_cfg.sv =====
module yuyv2rgb_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [yuyv2rgb_pkg::COEF_W-1:0] cfg_data,
    output yuyv2rgb_pkg::coef_t         coef
);
    import yuyv2rgb_pkg::*;

    coef_t coef_reg;
    coef_t coef_next;

    assign cfg_ready = 1'b1;
    assign coef      = coef_reg;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_LUMA_GAIN:     coef_next.luma_gain     = cfg_data;
                REG_RED_FROM_CR:   coef_next.red_from_cr   = cfg_data;
                REG_GREEN_FROM_CB: coef_next.green_from_cb = cfg_data;
                REG_GREEN_FROM_CR: coef_next.green_from_cr = cfg_data;
                REG_BLUE_FROM_CB:  coef_next.blue_from_cb  = cfg_data;
                default:           coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.luma_gain     <= LUMA_GAIN_RST;
            coef_reg.red_from_cr   <= RED_FROM_CR_RST;
            coef_reg.green_from_cb <= GREEN_FROM_CB_RST;
            coef_reg.green_from_cr <= GREEN_FROM_CR_RST;
            coef_reg.blue_from_cb  <= BLUE_FROM_CB_RST;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

endmodule

// ===== design/yuyv2rgb_mix.sv =====
module yuyv2rgb_mix (
    input  logic                            clk,
    input  logic                            rst_n,
    input  yuyv2rgb_pkg::coef_t             coef,
    input  logic                            in_valid,
    input  logic [yuyv2rgb_pkg::BYTE_W-1:0] luma_first,
    input  logic [yuyv2rgb_pkg::BYTE_W-1:0] chroma_blue,
    input  logic [yuyv2rgb_pkg::BYTE_W-1:0] luma_second,
    input  logic [yuyv2rgb_pkg::BYTE_W-1:0] chroma_red,
    input  logic                            frame_end,
    output logic                            sums_valid,
    output yuyv2rgb_pkg::chan_sums_t        sums,
    output logic                            sums_frame_end
);
    import yuyv2rgb_pkg::*;

    logic signed [DIFF_W-1:0] y1_diff;
    logic signed [DIFF_W-1:0] y2_diff;
    logic signed [DIFF_W-1:0] cb_diff;
    logic signed [DIFF_W-1:0] cr_diff;

    logic signed [PROD_W-1:0] lum1_next, lum1_reg;
    logic signed [PROD_W-1:0] lum2_next, lum2_reg;
    logic signed [PROD_W-1:0] rt_next, rt_reg;
    logic signed [PROD_W-1:0] gcb_next, gcb_reg;
    logic signed [PROD_W-1:0] gcr_next, gcr_reg;
    logic signed [PROD_W-1:0] bt_next, bt_reg;
    logic                     v1_reg, fe1_reg;

    logic signed [GSUM_W-1:0] gt;
    chan_sums_t               sums_next, sums_reg;
    logic                     v2_reg, fe2_reg;

    // stage 1: products
    always_comb
    begin
        y1_diff   = $signed({1'b0, luma_first}) - LUMA_OFFSET;
        y2_diff   = $signed({1'b0, luma_second}) - LUMA_OFFSET;
        cb_diff   = $signed({1'b0, chroma_blue}) - CHROMA_OFFSET;
        cr_diff   = $signed({1'b0, chroma_red}) - CHROMA_OFFSET;
        lum1_next = $signed({1'b0, coef.luma_gain}) * y1_diff;
        lum2_next = $signed({1'b0, coef.luma_gain}) * y2_diff;
        rt_next   = $signed({1'b0, coef.red_from_cr}) * cr_diff;
        gcb_next  = $signed({1'b0, coef.green_from_cb}) * cb_diff;
        gcr_next  = $signed({1'b0, coef.green_from_cr}) * cr_diff;
        bt_next   = $signed({1'b0, coef.blue_from_cb}) * cb_diff;
    end

    // stage 2: channel sums, chroma terms shared by both pixels
    always_comb
    begin
        gt                     = GSUM_W'(gcb_reg) + GSUM_W'(gcr_reg);
        sums_next.red_first    = SUM_W'(lum1_reg) + SUM_W'(rt_reg);
        sums_next.green_first  = SUM_W'(lum1_reg) - SUM_W'(gt);
        sums_next.blue_first   = SUM_W'(lum1_reg) + SUM_W'(bt_reg);
        sums_next.red_second   = SUM_W'(lum2_reg) + SUM_W'(rt_reg);
        sums_next.green_second = SUM_W'(lum2_reg) - SUM_W'(gt);
        sums_next.blue_second  = SUM_W'(lum2_reg) + SUM_W'(bt_reg);
    end

    always_ff @(posedge clk)
    begin
        lum1_reg <= lum1_next;
        lum2_reg <= lum2_next;
        rt_reg   <= rt_next;
        gcb_reg  <= gcb_next;
        gcr_reg  <= gcr_next;
        bt_reg   <= bt_next;
        fe1_reg  <= frame_end;
        sums_reg <= sums_next;
        fe2_reg  <= fe1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign sums_valid     = v2_reg;
    assign sums           = sums_reg;
    assign sums_frame_end = fe2_reg;

endmodule

// ===== design/yuyv2rgb_clamp.sv =====
module yuyv2rgb_clamp (
    input  logic                                  clk,
    input  logic signed [yuyv2rgb_pkg::SUM_W-1:0] sum,
    output logic [yuyv2rgb_pkg::BYTE_W-1:0]       chan
);
    import yuyv2rgb_pkg::*;

    logic               neg_reg;
    logic               over_reg;
    logic [QPROD_W-1:0] prod_next, prod_reg;
    logic [BYTE_W-1:0]  chan_next, chan_reg;

    // stage 3: reciprocal multiply
    assign prod_next = {{RECIP_W{1'b0}}, sum[FRAC_W-1:0]} * {{FRAC_W{1'b0}}, RECIP};

    // stage 4: saturate
    always_comb
    begin
        if (neg_reg)
            chan_next = '0;
        else if (over_reg)
            chan_next = CHAN_MAX;
        else
            chan_next = prod_reg[SHIFT+BYTE_W-1:SHIFT];
    end

    always_ff @(posedge clk)
    begin
        neg_reg  <= sum[SUM_W-1];
        over_reg <= $unsigned(sum) >= SAT_LIMIT;
        prod_reg <= prod_next;
        chan_reg <= chan_next;
    end

    assign chan = chan_reg;

endmodule

// ===== design/yuyv_to_rgb888_converter_top.sv =====
// YUYV 4:2:2 to RGB888 converter. One YUYV group (two luma bytes, shared Cb
// and Cr) is taken on every clock where start is high; busy stays low, so a
// group can be given every cycle. Each group yields one beat of two RGB888
// pixels, marked by result_valid for one cycle. It is registered in turn
// after the coefficient multipliers, the channel sums, the divide-by-1000
// reciprocal multiplier and the 0..255 clamp. The receiver cannot stall.
// Coefficient writes on the cfg channel are always ready and apply to groups
// taken on later cycles; write them while no group is in flight. Indexes
// above 4 are ignored.
module yuyv_to_rgb888_converter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [yuyv2rgb_pkg::BYTE_W-1:0] luma_first,
    input  logic [yuyv2rgb_pkg::BYTE_W-1:0] chroma_blue,
    input  logic [yuyv2rgb_pkg::BYTE_W-1:0] luma_second,
    input  logic [yuyv2rgb_pkg::BYTE_W-1:0] chroma_red,
    input  logic                            frame_end,
    output logic                            result_valid,
    output logic [yuyv2rgb_pkg::BYTE_W-1:0] red_first,
    output logic [yuyv2rgb_pkg::BYTE_W-1:0] green_first,
    output logic [yuyv2rgb_pkg::BYTE_W-1:0] blue_first,
    output logic [yuyv2rgb_pkg::BYTE_W-1:0] red_second,
    output logic [yuyv2rgb_pkg::BYTE_W-1:0] green_second,
    output logic [yuyv2rgb_pkg::BYTE_W-1:0] blue_second,
    output logic                            frame_end_out,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [2:0]                      cfg_index,
    input  logic [yuyv2rgb_pkg::COEF_W-1:0] cfg_data
);
    import yuyv2rgb_pkg::*;

    coef_t      coef;
    logic       accept;
    logic       sums_valid;
    chan_sums_t sums;
    logic       sums_frame_end;
    logic       v3_reg, v4_reg;
    logic       fe3_reg, fe4_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    yuyv2rgb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    yuyv2rgb_mix u_mix (
        .clk            (clk),
        .rst_n          (rst_n),
        .coef           (coef),
        .in_valid       (accept),
        .luma_first     (luma_first),
        .chroma_blue    (chroma_blue),
        .luma_second    (luma_second),
        .chroma_red     (chroma_red),
        .frame_end      (frame_end),
        .sums_valid     (sums_valid),
        .sums           (sums),
        .sums_frame_end (sums_frame_end)
    );

    yuyv2rgb_clamp u_red_first    (.clk(clk), .sum(sums.red_first),    .chan(red_first));
    yuyv2rgb_clamp u_green_first  (.clk(clk), .sum(sums.green_first),  .chan(green_first));
    yuyv2rgb_clamp u_blue_first   (.clk(clk), .sum(sums.blue_first),   .chan(blue_first));
    yuyv2rgb_clamp u_red_second   (.clk(clk), .sum(sums.red_second),   .chan(red_second));
    yuyv2rgb_clamp u_green_second (.clk(clk), .sum(sums.green_second), .chan(green_second));
    yuyv2rgb_clamp u_blue_second  (.clk(clk), .sum(sums.blue_second),  .chan(blue_second));

    always_ff @(posedge clk)
    begin
        fe3_reg <= sums_frame_end;
        fe4_reg <= fe3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= sums_valid;
            v4_reg <= v3_reg;
        end
    end

    assign result_valid  = v4_reg;
    assign frame_end_out = fe4_reg;

    a_beat_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 result_valid)
        else $error("accepted group produced no result beat");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(accept, 4))
        else $error("result beat without accepted group");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> frame_end_out == $past(frame_end, 4))
        else $error("frame end marker misaligned");

endmodule
